// File: src/sorted_priority_queue_assert.svh
// Assertion macros for the sorted priority queue checker.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// No dependencies; used by the top level and the port checker.
package spq_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic        [1:0]  command;
    logic signed [31:0] data_in;
    logic        [7:0]  priority_in;
    logic        [7:0]  new_priority;
  } spq_in_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] out_data;
    logic        [7:0]  out_priority;
    logic        [4:0]  entry_count;
    logic        [4:0]  matched_count;
  } spq_out_t;

endpackage

// File: src/sorted_priority_queue.sv
// Sorted priority queue: insert walks from the rear, shifting one entry per cycle.
// Delete shifts every entry forward. Update scans for matches and, when the priority
// changes, moves the tail and refills the matches.
// One transaction at a time; busy holds off the next, and the result strobes in the cycle
// after the last busy cycle. Full insert, empty delete, unknown command and update on empty
// answer next cycle. Synchronous active-low reset empties the queue; entries are not cleared.
module sorted_priority_queue #(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  spq_pkg::spq_in_t in_item,
  output logic             busy,
  output logic             out_valid,
  output spq_pkg::spq_out_t out_item
);
  import spq_pkg::*;

  localparam int PW = (PRIORITY_BITS < 8) ? PRIORITY_BITS : 8;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = 32 + PW;

  typedef enum logic [2:0] {
    S_IDLE, S_INS, S_DEL, S_SCAN, S_SHIFT, S_FILL
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   occ_r, occ_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic            rv_r, rv_nxt;
  logic [CW-1:0]   ri_r, ri_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic [CW-1:0]   w_r, w_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic [31:0]     data_r, data_nxt;
  logic [PW-1:0]   pold_r, pold_nxt;
  logic [PW-1:0]   pnew_r, pnew_nxt;
  logic            out_valid_r, out_valid_nxt;
  spq_out_t        out_r, out_nxt;

  logic            slot_we;
  logic [AW-1:0]   slot_waddr;
  logic [EW-1:0]   slot_wdata;
  logic [AW-1:0]   slot_raddr;
  logic [EW-1:0]   slot_rd;
  logic            buf_we;
  logic [AW-1:0]   buf_waddr;
  logic [AW-1:0]   buf_raddr;
  logic [31:0]     buf_rd;
  logic [PW-1:0]   r_prio;
  logic [31:0]     r_data;

  assign r_prio = slot_rd[EW-1:32];
  assign r_data = slot_rd[31:0];
  assign busy   = (state_r != S_IDLE);

  spq_mem #(.DEPTH(CAPACITY), .WIDTH(EW)) u_slot (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rd)
  );

  spq_mem #(.DEPTH(CAPACITY), .WIDTH(32)) u_match (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (r_data),
    .raddr (buf_raddr),
    .rdata (buf_rd)
  );

  always_comb begin
    spq_out_t res;
    res           = '0;
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    j_nxt         = j_r;
    rv_nxt        = 1'b0;
    ri_nxt        = ri_r;
    n_nxt         = n_r;
    w_nxt         = w_r;
    pos_nxt       = pos_r;
    data_nxt      = data_r;
    pold_nxt      = pold_r;
    pnew_nxt      = pnew_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    slot_we       = 1'b0;
    slot_waddr    = '0;
    slot_wdata    = slot_rd;
    slot_raddr    = '0;
    buf_we        = 1'b0;
    buf_waddr     = AW'(n_r);
    buf_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          data_nxt  = in_item.data_in;
          pold_nxt  = in_item.priority_in[PW-1:0];
          pnew_nxt  = in_item.new_priority[PW-1:0];
          res.entry_count = 5'(occ_r);
          case (in_item.command)
            CMD_INSERT: begin
              if (occ_r == CW'(CAPACITY)) begin
                res.status    = ST_FULL;
                out_valid_nxt = 1'b1;
                out_nxt       = res;
              end else begin
                state_nxt = S_INS;
                j_nxt     = occ_r;
              end
            end
            CMD_DELETE: begin
              if (occ_r == '0) begin
                res.status    = ST_EMPTY;
                out_valid_nxt = 1'b1;
                out_nxt       = res;
              end else begin
                state_nxt = S_DEL;
                j_nxt     = '0;
              end
            end
            CMD_UPDATE: begin
              if (occ_r == '0) begin
                res.status    = ST_NOTFOUND;
                out_valid_nxt = 1'b1;
                out_nxt       = res;
              end else begin
                state_nxt = S_SCAN;
                j_nxt     = '0;
                n_nxt     = '0;
                w_nxt     = '0;
                pos_nxt   = '0;
              end
            end
            default: begin
              res.status    = ST_OK;
              out_valid_nxt = 1'b1;
              out_nxt       = res;
            end
          endcase
        end
      end

      S_INS: begin
        if (j_r != '0) begin
          slot_raddr = AW'(j_r - 1'b1);
          rv_nxt     = 1'b1;
          ri_nxt     = j_r - 1'b1;
          j_nxt      = j_r - 1'b1;
        end
        if (rv_r) begin
          slot_we    = 1'b1;
          slot_waddr = AW'(ri_r + 1'b1);
          if (r_prio >= pold_r) begin
            slot_wdata = {pold_r, data_r};
            rv_nxt     = 1'b0;
            occ_nxt    = occ_r + 1'b1;
            res.status      = ST_OK;
            res.entry_count = 5'(occ_r + 1'b1);
            out_valid_nxt   = 1'b1;
            out_nxt         = res;
            state_nxt       = S_IDLE;
          end
        end else if (j_r == '0) begin
          slot_we    = 1'b1;
          slot_waddr = '0;
          slot_wdata = {pold_r, data_r};
          occ_nxt    = occ_r + 1'b1;
          res.status      = ST_OK;
          res.entry_count = 5'(occ_r + 1'b1);
          out_valid_nxt   = 1'b1;
          out_nxt         = res;
          state_nxt       = S_IDLE;
        end
      end

      S_DEL: begin
        if (j_r < occ_r) begin
          slot_raddr = AW'(j_r);
          rv_nxt     = 1'b1;
          ri_nxt     = j_r;
          j_nxt      = j_r + 1'b1;
        end
        if (rv_r) begin
          if (ri_r == '0) begin
            data_nxt = r_data;
            pold_nxt = r_prio;
          end else begin
            slot_we    = 1'b1;
            slot_waddr = AW'(ri_r - 1'b1);
          end
          if (ri_r == occ_r - 1'b1) begin
            rv_nxt  = 1'b0;
            occ_nxt = occ_r - 1'b1;
            res.status       = ST_OK;
            res.out_data     = (ri_r == '0) ? r_data : data_r;
            res.out_priority = 8'((ri_r == '0) ? r_prio : pold_r);
            res.entry_count  = 5'(occ_r - 1'b1);
            out_valid_nxt    = 1'b1;
            out_nxt          = res;
            state_nxt        = S_IDLE;
          end
        end
      end

      S_SCAN: begin
        if (j_r < occ_r) begin
          slot_raddr = AW'(j_r);
          rv_nxt     = 1'b1;
          ri_nxt     = j_r;
          j_nxt      = j_r + 1'b1;
        end
        if (rv_r) begin
          if (r_prio == pold_r) begin
            buf_we = 1'b1;
            n_nxt  = n_r + 1'b1;
          end else begin
            slot_we    = (pnew_r != pold_r);
            slot_waddr = AW'(w_r);
            w_nxt      = w_r + 1'b1;
            if (r_prio >= pnew_r) begin
              pos_nxt = pos_r + 1'b1;
            end
          end
          if (ri_r == occ_r - 1'b1) begin
            rv_nxt          = 1'b0;
            res.entry_count = 5'(occ_r);
            if (n_nxt == '0) begin
              res.status    = ST_NOTFOUND;
              out_valid_nxt = 1'b1;
              out_nxt       = res;
              state_nxt     = S_IDLE;
            end else if (pnew_r == pold_r) begin
              res.status        = ST_OK;
              res.matched_count = 5'(n_nxt);
              out_valid_nxt     = 1'b1;
              out_nxt           = res;
              state_nxt         = S_IDLE;
            end else begin
              j_nxt     = w_nxt;
              state_nxt = S_SHIFT;
            end
          end
        end
      end

      S_SHIFT: begin
        if (j_r > pos_r) begin
          slot_raddr = AW'(j_r - 1'b1);
          rv_nxt     = 1'b1;
          ri_nxt     = j_r - 1'b1;
          j_nxt      = j_r - 1'b1;
        end
        if (rv_r) begin
          slot_we    = 1'b1;
          slot_waddr = AW'(ri_r + n_r);
        end else if (j_r == pos_r) begin
          j_nxt     = '0;
          state_nxt = S_FILL;
        end
      end

      S_FILL: begin
        if (j_r < n_r) begin
          buf_raddr = AW'(n_r - 1'b1 - j_r);
          rv_nxt    = 1'b1;
          ri_nxt    = j_r;
          j_nxt     = j_r + 1'b1;
        end
        if (rv_r) begin
          slot_we    = 1'b1;
          slot_waddr = AW'(pos_r + ri_r);
          slot_wdata = {pnew_r, buf_rd};
          if (ri_r == n_r - 1'b1) begin
            rv_nxt            = 1'b0;
            res.status        = ST_OK;
            res.entry_count   = 5'(occ_r);
            res.matched_count = 5'(n_r);
            out_valid_nxt     = 1'b1;
            out_nxt           = res;
            state_nxt         = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    j_r    <= j_nxt;
    ri_r   <= ri_nxt;
    n_r    <= n_nxt;
    w_r    <= w_nxt;
    pos_r  <= pos_nxt;
    data_r <= data_nxt;
    pold_r <= pold_nxt;
    pnew_r <= pnew_nxt;
    out_r  <= out_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: src/spq_mem.sv
// Simple dual-port memory: one write port, one registered read port.
// No dependencies; used for entry storage and the update match buffer.
module spq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/spq_check.sv
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_assert.svh.
`include "sorted_priority_queue_assert.svh"

module spq_check (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input spq_pkg::spq_out_t out_item
);
  import spq_pkg::*;

  `SPQ_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid,
                   "accepted transaction neither busy nor answered")
  `SPQ_ASSERT_NOW(a_result_idle, out_valid, !busy, "result shown while busy")
  `SPQ_ASSERT_NOW(a_rise_quiet, $rose(busy), !out_valid,
                  "result alongside a new transaction")
  `SPQ_ASSERT_NOW(a_empty_zero, out_valid && out_item.status == ST_EMPTY,
                  {out_item.out_data, out_item.out_priority, out_item.entry_count} == '0,
                  "underflow result not zero")

endmodule

bind sorted_priority_queue spq_check u_spq_check (.*);

// File: verif/tb_sorted_priority_queue.sv
// Self-checking testbench for sorted_priority_queue: directed table, then random transactions.
// Models the sorted entries; checks every result field against it or a directed row's want.
// Depends on spq_pkg and the sorted_priority_queue top level.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int DEPTH            = 16;
  localparam int CYCLE_LIMIT      = 500000;
  localparam int DRAIN_CYCLES     = 60;
  localparam int RANDOM_PER_PHASE = 384;
  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam logic [7:0] PRIO_POOL [4] = '{8'h00, 8'h10, 8'h11, 8'hFF};

  typedef struct {
    spq_in_t  item;
    int       reps;
    bit       has_want;
    spq_out_t want;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  spq_in_t  in_item = '0;
  logic     busy;
  logic     out_valid;
  spq_out_t out_item;

  logic signed [31:0] held_data [DEPTH];
  logic        [7:0]  held_prio [DEPTH];
  int                 held_count = 0;

  spq_out_t pending_results [$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       sender_idle_pct = 10;

  stim_row_t directed_rows [17] = '{
    '{{CMD_DELETE,  32'h0000_0000, 8'd0,   8'd0},   1, 1'b1,
      {ST_EMPTY,    32'h0000_0000, 8'h00, 5'd0, 5'd0}},
    '{{CMD_UPDATE,  32'h0000_0000, 8'd5,   8'd6},   1, 1'b1,
      {ST_NOTFOUND, 32'h0000_0000, 8'h00, 5'd0, 5'd0}},
    '{{CMD_IGNORED, 32'h0000_0000, 8'd0,   8'd0},   1, 1'b1,
      {ST_OK,       32'h0000_0000, 8'h00, 5'd0, 5'd0}},
    '{{CMD_INSERT,  32'h7FFF_FFFF, 8'd0,   8'd0},   1, 1'b1,
      {ST_OK,       32'h0000_0000, 8'h00, 5'd1, 5'd0}},
    '{{CMD_INSERT,  32'h8000_0000, 8'd255, 8'd0},   1, 1'b1,
      {ST_OK,       32'h0000_0000, 8'h00, 5'd2, 5'd0}},
    '{{CMD_INSERT,  32'hFFFF_FFFF, 8'd255, 8'd0},   1, 1'b1,
      {ST_OK,       32'h0000_0000, 8'h00, 5'd3, 5'd0}},
    '{{CMD_INSERT,  32'h0000_0000, 8'd128, 8'd0},   1, 1'b1,
      {ST_OK,       32'h0000_0000, 8'h00, 5'd4, 5'd0}},
    '{{CMD_DELETE,  32'h0000_0000, 8'd0,   8'd0},   1, 1'b1,
      {ST_OK,       32'h8000_0000, 8'hFF, 5'd3, 5'd0}},
    '{{CMD_UPDATE,  32'h0000_0000, 8'd255, 8'd0},   1, 1'b1,
      {ST_OK,       32'h0000_0000, 8'h00, 5'd3, 5'd1}},
    '{{CMD_UPDATE,  32'h0000_0000, 8'd7,   8'd9},   1, 1'b1,
      {ST_NOTFOUND, 32'h0000_0000, 8'h00, 5'd3, 5'd0}},
    '{{CMD_UPDATE,  32'h0000_0000, 8'd0,   8'd0},   1, 1'b1,
      {ST_OK,       32'h0000_0000, 8'h00, 5'd3, 5'd2}},
    '{{CMD_IGNORED, 32'hFFFF_FFFF, 8'd255, 8'd255}, 1, 1'b1,
      {ST_OK,       32'h0000_0000, 8'h00, 5'd3, 5'd0}},
    '{{CMD_INSERT,  32'h5A5A_5A5A, 8'h55,  8'd0},   6, 1'b0, '0},
    '{{CMD_INSERT,  32'hA5A5_A5A5, 8'hAA,  8'd0},   7, 1'b0, '0},
    '{{CMD_INSERT,  32'h1234_5678, 8'h80,  8'd0},   1, 1'b1,
      {ST_FULL,     32'h0000_0000, 8'h00, 5'd16, 5'd0}},
    '{{CMD_UPDATE,  32'h0000_0000, 8'h55,  8'hAA},  1, 1'b0, '0},
    '{{CMD_UPDATE,  32'h0000_0000, 8'hAA,  8'h01},  1, 1'b0, '0}
  };

  sorted_priority_queue uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void place_entry(logic signed [31:0] d, logic [7:0] p);
    int pos;
    if (held_count >= DEPTH) return;
    pos = 0;
    while (pos < held_count && held_prio[pos] >= p) pos++;
    for (int j = held_count; j > pos; j--) begin
      held_data[j] = held_data[j-1];
      held_prio[j] = held_prio[j-1];
    end
    held_data[pos] = d;
    held_prio[pos] = p;
    held_count++;
  endfunction

  function automatic spq_out_t apply_queue_command(spq_in_t it);
    spq_out_t           res;
    logic signed [31:0] moved [DEPTH];
    int                 n_moved;
    int                 kept;
    res = '0;
    n_moved = 0;
    kept = 0;
    case (it.command)
      CMD_INSERT: begin
        if (held_count >= DEPTH) res.status = ST_FULL;
        else place_entry(it.data_in, it.priority_in);
      end
      CMD_DELETE: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_data = held_data[0];
          res.out_priority = held_prio[0];
          for (int i = 1; i < held_count; i++) begin
            held_data[i-1] = held_data[i];
            held_prio[i-1] = held_prio[i];
          end
          held_count--;
        end
      end
      CMD_UPDATE: begin
        for (int i = 0; i < held_count; i++)
          if (held_prio[i] == it.priority_in) res.matched_count++;
        if (res.matched_count == 0) begin
          res.status = ST_NOTFOUND;
        end else if (it.new_priority != it.priority_in) begin
          for (int i = held_count - 1; i >= 0; i--) begin
            if (held_prio[i] == it.priority_in) begin
              moved[n_moved] = held_data[i];
              n_moved++;
            end
          end
          for (int i = 0; i < held_count; i++) begin
            if (held_prio[i] != it.priority_in) begin
              held_data[kept] = held_data[i];
              held_prio[kept] = held_prio[i];
              kept++;
            end
          end
          held_count = kept;
          for (int i = 0; i < n_moved; i++) place_entry(moved[i], it.new_priority);
        end
      end
      default: ;
    endcase
    res.entry_count = 5'(held_count);
    return res;
  endfunction

  function automatic logic [7:0] pick_priority();
    if ($urandom_range(0, 1) != 0) return 8'($urandom_range(0, 255));
    return PRIO_POOL[$urandom_range(0, 3)];
  endfunction

  function automatic spq_in_t random_command(int fill_pct);
    spq_in_t it;
    int      roll;
    roll = $urandom_range(0, 99);
    it.data_in = $urandom;
    it.priority_in = pick_priority();
    it.new_priority = pick_priority();
    if (roll < 4) begin
      it.command = CMD_IGNORED;
    end else if (roll < 4 + fill_pct) begin
      it.command = CMD_INSERT;
    end else if (roll < 4 + fill_pct + (96 - fill_pct) / 2) begin
      it.command = CMD_DELETE;
    end else begin
      it.command = CMD_UPDATE;
      if (held_count > 0 && $urandom_range(0, 3) != 0)
        it.priority_in = held_prio[$urandom_range(0, held_count - 1)];
      case ($urandom_range(0, 3))
        0: it.new_priority = it.priority_in;
        1: if (held_count > 0) it.new_priority = held_prio[$urandom_range(0, held_count - 1)];
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s at %0t: got %h, want %h", field, $time, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(spq_out_t got, spq_out_t want);
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
    if (got.out_data !== want.out_data) report_mismatch("out_data", got.out_data, want.out_data);
    if (got.out_priority !== want.out_priority)
      report_mismatch("out_priority", 32'(got.out_priority), 32'(want.out_priority));
    if (got.entry_count !== want.entry_count)
      report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
    if (got.matched_count !== want.matched_count)
      report_mismatch("matched_count", 32'(got.matched_count), 32'(want.matched_count));
  endtask

  // hold start until the transaction is taken, then queue its expected result
  task automatic send_command(spq_in_t it, bit has_want, spq_out_t want);
    spq_out_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_queue_command(it);
    pending_results.push_back(has_want ? want : predicted);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_item.status), 32'(ST_OK));
      end else begin
        check_result(out_item, pending_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    spq_in_t it;
    int      fill_pct;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[k]) begin
      for (int r = 0; r < directed_rows[k].reps; r++) begin
        it = directed_rows[k].item;
        it.data_in = directed_rows[k].item.data_in + 32'(r);
        send_command(it, directed_rows[k].has_want, directed_rows[k].want);
      end
    end
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 63 : 0;
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        fill_pct = ((k / 48) % 2 != 0) ? 25 : 60;
        send_command(random_command(fill_pct), 1'b0, '0);
      end
    end
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
